### hw/rtl/cafilt_pkg.sv
// Shared constants and helpers for the complementary attitude filter.
// CORDIC angle table, angle limits and saturation. No dependencies.
`timescale 1ns / 1ps
package cafilt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ACC_W        = 48;
  localparam int VEC_W        = 28;
  localparam int ANG_W        = 25;

  localparam logic signed [ANG_W-1:0] ANG_90    = 25'sd2949120;
  localparam logic signed [ACC_W-1:0] ANG_LIMIT = 48'sd5898240;
  localparam logic signed [17:0]      INV_GAIN  = 18'sd39797;

  // atan(2^-i) in 1/32768 degree, rounded
  function automatic logic [20:0] atan_lut(input logic [4:0] i);
    logic [20:0] r;
    case (i)
      5'd0:    r = 21'd1474560;
      5'd1:    r = 21'd870484;
      5'd2:    r = 21'd459940;
      5'd3:    r = 21'd233473;
      5'd4:    r = 21'd117189;
      5'd5:    r = 21'd58652;
      5'd6:    r = 21'd29333;
      5'd7:    r = 21'd14667;
      5'd8:    r = 21'd7334;
      5'd9:    r = 21'd3667;
      5'd10:   r = 21'd1833;
      5'd11:   r = 21'd917;
      5'd12:   r = 21'd458;
      5'd13:   r = 21'd229;
      5'd14:   r = 21'd115;
      5'd15:   r = 21'd57;
      5'd16:   r = 21'd29;
      5'd17:   r = 21'd14;
      5'd18:   r = 21'd7;
      5'd19:   r = 21'd4;
      5'd20:   r = 21'd2;
      5'd21:   r = 21'd1;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

  // clamp to +-180 degrees
  function automatic logic signed [23:0] sat_ang(input logic signed [ACC_W-1:0] v);
    logic signed [23:0] r;
    if (v > ANG_LIMIT) begin
      r = 24'(ANG_LIMIT);
    end else if (v < -ANG_LIMIT) begin
      r = 24'(-ANG_LIMIT);
    end else begin
      r = 24'(v);
    end
    return r;
  endfunction

endpackage

### hw/rtl/complementary_attitude_filter.sv
// Complementary attitude filter top level: CORDIC atan2, serial multiplier, blend.
// Depends on cafilt_pkg.
// A seed item runs the roll CORDIC pass, the magnitude product and the pitch pass
// (a zero vector skips the iterations); an update item adds six more products in
// the bit-serial multiplier. One item at a time: the next item
// is taken the cycle after the result is registered; a stalled result holds S_OUT.
// Reset (async, active low) sets blend_weight 64225, sample_period 10486,
// both estimates to zero and the result register empty.
`timescale 1ns / 1ps
module complementary_attitude_filter import cafilt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CPRE, S_CITER, S_CDONE, S_MUL, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    J_MAG, J_PG, J_RG, J_PA, J_PB, J_RA, J_RB
  } job_e;

  localparam logic [1:0] REG_BLEND  = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [4:0] LAST_IT    = 5'(CORDIC_STEPS - 1);
  localparam logic [4:0] MUL_LAST   = 5'd17;

  state_e state_q;
  job_e   job_q;
  logic   pass_q;   // 0 roll vector, 1 pitch vector
  logic   op_q;

  logic [15:0] bw_q;
  logic [19:0] dt_q;

  logic signed [15:0] ax_q, rx_q, ry_q;
  logic signed [VEC_W-1:0] x_q, y_q;
  logic signed [ANG_W-1:0] z_q;
  logic [4:0]              it_q;

  logic signed [23:0] pitch_acc_q, roll_acc_q;
  logic signed [23:0] pitch_est_q, roll_est_q;
  logic signed [27:0] pg_q, rg_q;

  logic signed [ACC_W-1:0] acc_q, mcand_q;
  logic signed [17:0]      mplier_q;
  logic [4:0]              cnt_q;

  logic                    out_valid_q;
  logic signed [15:0]      pitch_q, roll_q;

  // CORDIC step
  logic signed [VEC_W-1:0] xs, ys;
  logic signed [ANG_W-1:0] at;
  // serial multiplier: last multiplier bit carries negative weight
  logic signed [ACC_W-1:0] addend, acc_n;
  logic signed [17:0]      w_a, w_b;

  always_comb begin
    xs     = x_q >>> it_q;
    ys     = y_q >>> it_q;
    at     = ANG_W'($signed({1'b0, atan_lut(it_q)}));
    addend = mplier_q[0] ? ((cnt_q == MUL_LAST) ? -mcand_q : mcand_q) : '0;
    acc_n  = acc_q + addend;
    w_a    = 18'($signed({1'b0, bw_q}));
    w_b    = 18'sd65536 - w_a;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pitch_angle_o = pitch_q;
  assign roll_angle_o  = roll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= J_MAG;
      pass_q      <= 1'b0;
      op_q        <= 1'b0;
      bw_q        <= 16'd64225;
      dt_q        <= 20'd10486;
      pitch_est_q <= '0;
      roll_est_q  <= '0;
      out_valid_q <= 1'b0;
      it_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BLEND:  bw_q <= cfg_data_i[15:0];
          REG_PERIOD: dt_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_i;
            ax_q    <= accel_x_i;
            rx_q    <= rate_x_i;
            ry_q    <= rate_y_i;
            x_q     <= VEC_W'(accel_z_i) <<< 8;
            y_q     <= VEC_W'(accel_y_i) <<< 8;
            pass_q  <= 1'b0;
            state_q <= S_CPRE;
          end
        end

        // zero vector skips the iterations; left half plane turned by 90 degrees
        S_CPRE: begin
          it_q <= '0;
          if (x_q == '0 && y_q == '0) begin
            z_q     <= '0;
            state_q <= S_CDONE;
          end else begin
            state_q <= S_CITER;
            if (x_q[VEC_W-1]) begin
              if (!y_q[VEC_W-1]) begin
                x_q <= y_q;
                y_q <= -x_q;
                z_q <= ANG_90;
              end else begin
                x_q <= -y_q;
                y_q <= x_q;
                z_q <= -ANG_90;
              end
            end else begin
              z_q <= '0;
            end
          end
        end

        S_CITER: begin
          if (!y_q[VEC_W-1]) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end
          it_q <= it_q + 5'd1;
          if (it_q == LAST_IT) begin
            state_q <= S_CDONE;
          end
        end

        S_CDONE: begin
          acc_q <= '0;
          cnt_q <= '0;
          if (!pass_q) begin
            roll_acc_q <= sat_ang(ACC_W'(z_q));
            mcand_q    <= ACC_W'(x_q);
            mplier_q   <= INV_GAIN;
            job_q      <= J_MAG;
            state_q    <= S_MUL;
          end else begin
            pitch_acc_q <= sat_ang(ACC_W'(z_q));
            if (op_q) begin
              pitch_est_q <= sat_ang(ACC_W'(z_q));
              roll_est_q  <= roll_acc_q;
              state_q     <= S_OUT;
            end else begin
              mcand_q  <= ACC_W'($signed({1'b0, dt_q}));
              mplier_q <= 18'(ry_q);
              job_q    <= J_PG;
              state_q  <= S_MUL;
            end
          end
        end

        S_MUL: begin
          acc_q    <= acc_n;
          mcand_q  <= mcand_q <<< 1;
          mplier_q <= mplier_q >>> 1;
          cnt_q    <= cnt_q + 5'd1;
          if (cnt_q == MUL_LAST) begin
            cnt_q <= '0;
            case (job_q)
              J_MAG: begin
                // magnitude times 1/K feeds the pitch vector
                x_q     <= VEC_W'((acc_n + 48'sd32768) >>> 16);
                y_q     <= -(VEC_W'(ax_q) <<< 8);
                pass_q  <= 1'b1;
                state_q <= S_CPRE;
              end
              J_PG: begin
                pg_q     <= 28'(pitch_est_q) + 28'((acc_n + 48'sd256) >>> 9);
                acc_q    <= '0;
                mcand_q  <= ACC_W'($signed({1'b0, dt_q}));
                mplier_q <= 18'(rx_q);
                job_q    <= J_RG;
              end
              J_RG: begin
                rg_q     <= 28'(roll_est_q) + 28'((acc_n + 48'sd256) >>> 9);
                acc_q    <= '0;
                mcand_q  <= ACC_W'(pg_q);
                mplier_q <= w_a;
                job_q    <= J_PA;
              end
              J_PA: begin
                mcand_q  <= ACC_W'(pitch_acc_q);
                mplier_q <= w_b;
                job_q    <= J_PB;
              end
              J_PB: begin
                pitch_est_q <= sat_ang((acc_n + 48'sd32768) >>> 16);
                acc_q       <= '0;
                mcand_q     <= ACC_W'(rg_q);
                mplier_q    <= w_a;
                job_q       <= J_RA;
              end
              J_RA: begin
                mcand_q  <= ACC_W'(roll_acc_q);
                mplier_q <= w_b;
                job_q    <= J_RB;
              end
              J_RB: begin
                roll_est_q <= sat_ang((acc_n + 48'sd32768) >>> 16);
                state_q    <= S_OUT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end

        // round to 1/128 degree into the result register
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            pitch_q     <= 16'((25'(pitch_est_q) + 25'sd128) >>> 8);
            roll_q      <= 16'((25'(roll_est_q) + 25'sd128) >>> 8);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while idle did not start work");

  a_est_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ACC_W'(pitch_est_q) <= ANG_LIMIT) && (ACC_W'(pitch_est_q) >= -ANG_LIMIT) &&
    (ACC_W'(roll_est_q) <= ANG_LIMIT) && (ACC_W'(roll_est_q) >= -ANG_LIMIT))
    else $error("estimate beyond 180 degrees");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MUL_LAST)
    else $error("multiplier count overran");
`endif

endmodule
